>>> sv/csem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csem_pkg
// Shared types and constants of the counting semaphore table.
// ============================================================================
package csem_pkg;

  localparam int unsigned SEM_COUNT_DEF = 16;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned ENTRY_W       = ID_W + CNT_W;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_UP    = 2'd2,
    OP_DOWN  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_FULL        = 3'd1,
    STAT_NOT_FOUND   = 3'd2,
    STAT_WOULD_BLOCK = 3'd3,
    STAT_OVERFLOW    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB,
    S_DONE
  } fsm_state_e;

  // One answer of the table
  typedef struct packed {
    logic             wake;
    logic [CNT_W-1:0] count;
    status_e          status;
  } result_t;

endpackage : csem_pkg
`default_nettype wire

>>> sv/csem_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csem_mem
// Entry store: identifier and count per entry, one write and one registered
// read port.
// ============================================================================
module csem_mem
  import csem_pkg::*;
#(
  parameter int unsigned SEM_COUNT = SEM_COUNT_DEF,
  localparam int unsigned IDX_W    = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IDX_W-1:0]   waddr_i,
  input  wire logic [ENTRY_W-1:0] wdata_i,
  input  wire logic               re_i,
  input  wire logic [IDX_W-1:0]   raddr_i,
  output logic      [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [SEM_COUNT];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : csem_mem
`default_nettype wire

>>> sv/csem_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// csem_fsm
// Request sequencer: scans the entry store one entry a cycle, holds the
// valid marks and writes the modified entry back.
// ============================================================================
module csem_fsm
  import csem_pkg::*;
#(
  parameter int unsigned SEM_COUNT = SEM_COUNT_DEF,
  localparam int unsigned IDX_W    = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request side
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire op_e                req_op_i,
  input  wire logic [ID_W-1:0]    req_id_i,
  input  wire logic [CNT_W-1:0]   req_init_i,
  // result side
  output logic                    res_valid_o,
  input  wire logic               res_take_i,
  output result_t                 res_o,
  // entry store
  output logic                    mem_we_o,
  output logic [IDX_W-1:0]        mem_waddr_o,
  output logic [ENTRY_W-1:0]      mem_wdata_o,
  output logic                    mem_re_o,
  output logic [IDX_W-1:0]        mem_raddr_o,
  input  wire logic [ENTRY_W-1:0] mem_rdata_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEM_COUNT - 1);

  fsm_state_e       state_q, state_d;
  op_e              op_q;
  logic [ID_W-1:0]  id_q;
  logic [CNT_W-1:0] init_q;
  logic [IDX_W-1:0] idx_q;
  logic             issue_q;
  logic             chk_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SEM_COUNT-1:0] valid_q;
  result_t          res_q, res_d;

  logic             start;
  logic             hit_now;
  logic             stop;
  logic [ID_W-1:0]  rd_id;
  logic [CNT_W-1:0] rd_cnt;

  assign rd_id  = mem_rdata_i[ENTRY_W-1:CNT_W];
  assign rd_cnt = mem_rdata_i[CNT_W-1:0];
  assign start  = req_valid_i && req_ready_o;

  // Open looks for a free entry, the others for a valid entry with the id
  always_comb begin
    if (op_q == OP_OPEN) begin
      hit_now = chk_q && !valid_q[chk_idx_q];
    end else begin
      hit_now = chk_q && valid_q[chk_idx_q] && (rd_id == id_q);
    end
  end

  assign stop = hit_now || (chk_q && (chk_idx_q == LAST_IDX));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_SCAN;
      S_SCAN:  if (stop) state_d = S_WB;
      S_WB:    state_d = S_DONE;
      S_DONE:  if (res_take_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and write-back
  always_comb begin
    req_ready_o  = (state_q == S_IDLE);
    res_valid_o  = (state_q == S_DONE);
    mem_re_o     = (state_q == S_SCAN) && issue_q;
    mem_raddr_o  = idx_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = hit_idx_q;
    mem_wdata_o  = {id_q, init_q};
    res_d.status = STAT_OK;
    res_d.count  = '0;
    res_d.wake   = 1'b0;
    if (state_q == S_WB) begin
      if (!hit_q) begin
        res_d.status = (op_q == OP_OPEN) ? STAT_FULL : STAT_NOT_FOUND;
      end else begin
        case (op_q)
          OP_OPEN: begin
            mem_we_o    = 1'b1;
            res_d.count = init_q;
          end
          OP_CLOSE: begin
            res_d.wake = 1'b1;
          end
          OP_UP: begin
            if (cnt_q == COUNT_MAX) begin
              res_d.status = STAT_OVERFLOW;
              res_d.count  = cnt_q;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {id_q, cnt_q + CNT_W'(1)};
              res_d.count = cnt_q + CNT_W'(1);
              res_d.wake  = (cnt_q == '0);
            end
          end
          OP_DOWN: begin
            if (cnt_q == '0) begin
              res_d.status = STAT_WOULD_BLOCK;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {id_q, cnt_q - CNT_W'(1)};
              res_d.count = cnt_q - CNT_W'(1);
            end
          end
          default: res_d.status = STAT_NOT_FOUND;
        endcase
      end
    end
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      issue_q <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        issue_q <= 1'b1;
        chk_q   <= 1'b0;
      end else if (state_q == S_SCAN) begin
        // advance the read pointer, drop the compare slot once done
        if (stop) begin
          issue_q <= 1'b0;
          chk_q   <= 1'b0;
        end else begin
          issue_q <= issue_q && (idx_q != LAST_IDX);
          chk_q   <= issue_q;
        end
      end
      if (state_q == S_WB && hit_q) begin
        if (op_q == OP_OPEN) begin
          valid_q[hit_idx_q] <= 1'b1;
        end else if (op_q == OP_CLOSE) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q   <= req_op_i;
      id_q   <= req_id_i;
      init_q <= req_init_i;
      idx_q  <= '0;
    end else if (state_q == S_SCAN) begin
      if (issue_q) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      chk_idx_q <= idx_q;
      if (stop) begin
        hit_q     <= hit_now;
        hit_idx_q <= chk_idx_q;
        cnt_q     <= rd_cnt;
      end
    end
    if (state_q == S_WB) begin
      res_q <= res_d;
    end
  end

  // A compare slot exists only while scanning
  a_chk_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_q |-> (state_q == S_SCAN))
    else $error("compare slot live outside scan");

  // Up, down and close only ever act on a valid entry
  a_hit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && hit_q && op_q != OP_OPEN) |-> valid_q[hit_idx_q])
    else $error("hit on a free entry");

  // A successful open marks its entry valid
  a_open_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && hit_q && op_q == OP_OPEN) |=> valid_q[$past(hit_idx_q)])
    else $error("opened entry not marked valid");

endmodule : csem_fsm
`default_nettype wire

>>> sv/counting_semaphore_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// counting_semaphore_table_core
// Table of counting semaphores served over a request and a result stream.
// ============================================================================
// Usage:
//   Send a request on the slave stream: op in tuser (open, close, up, down),
//   identifier and starting count in tdata. Each request returns exactly one
//   result on the master stream: status and wake in tuser, count in tdata.
//   Requests are served one at a time. A request scans the entry store one
//   entry per cycle through its single registered read port, stopping at
//   the first matching entry, then passes through a write-back state, which
//   registers the result, and waits in a done state until the result is
//   taken by the output register. The sequencer is then ready again, the next
//   request being taken the cycle after the result is handed to the output
//   register. The output register holds one finished result, so a stalled
//   receiver does not block the next request from being accepted and
//   scanned; the sequencer waits only when it has a second result ready.
//   Reset clears every valid mark at once, so the table is empty and ready
//   in the first cycle after reset; identifiers and counts are not cleared.
// ============================================================================
module counting_semaphore_table_core
  import csem_pkg::*;
#(
  parameter int unsigned SEM_COUNT = SEM_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [15:0] sem_id, [31:16] init_value
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] count_after
  output logic [3:0]       m_axis_tuser   // [2:0] status, [3] wake
);

  localparam int unsigned IDX_W = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic    res_valid;
  logic    res_take;
  result_t res;

  logic    out_valid_q;
  result_t out_q;

  // Output register free, or being emptied this cycle
  assign res_take = !out_valid_q || m_axis_tready;

  csem_fsm #(
    .SEM_COUNT (SEM_COUNT)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_op_i    (op_e'(s_axis_tuser)),
    .req_id_i    (s_axis_tdata[15:0]),
    .req_init_i  (s_axis_tdata[31:16]),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  csem_mem #(
    .SEM_COUNT (SEM_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load a finished result, hold it while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.count;
  assign m_axis_tuser  = {out_q.wake, out_q.status};

endmodule : counting_semaphore_table_core
`default_nettype wire
